// ===== sv/pnas_pkg.sv =====
package pnas_pkg;

    localparam int MAX_ATOMS_DEF  = 256;
    localparam int COORD_BITS_DEF = 20;
    localparam int CFG_BITS       = 60;
    localparam int CFG_IDX_BITS   = 2;
    localparam int DSQ_BITS       = 45;
    localparam int DIST_BITS      = 23;
    localparam int IDX_BITS       = 8;
    localparam int CNT_BITS       = 9;
    localparam int IMAGES         = 27;

    localparam logic [CFG_IDX_BITS-1:0] REG_LATTICE_A  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LATTICE_B  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LATTICE_C  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ATOM_COUNT = 2'd3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IMAGE,
        ST_SCAN,
        ST_SQRT,
        ST_OUT
    } state_t;

endpackage

// ===== sv/pnas_ram.sv =====
module pnas_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/pnas_sqrt.sv =====
module pnas_sqrt import pnas_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DSQ_BITS-1:0]  value,
    output logic                 done,
    output logic [DIST_BITS-1:0] root
);

    localparam int STEPS = DIST_BITS;
    localparam int RW    = DSQ_BITS + 3;

    logic [RW-1:0]            rem_reg, rem_next;
    logic [DIST_BITS-1:0]     root_reg, root_next;
    logic [2*DIST_BITS-1:0]   src_reg, src_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic [RW-1:0]            trial;
    logic [RW-1:0]            shifted;

    always_comb begin
        shifted   = {rem_reg[RW-3:0], src_reg[2*DIST_BITS-1 -: 2]};
        trial     = {{(RW-DIST_BITS-2){1'b0}}, root_reg, 2'b01};
        rem_next  = rem_reg;
        root_next = root_reg;
        src_next  = src_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            root_next = '0;
            src_next  = {1'b0, value};
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            src_next = {src_reg[2*DIST_BITS-3:0], 2'b00};
            if (shifted >= trial) begin
                rem_next  = shifted - trial;
                root_next = {root_reg[DIST_BITS-2:0], 1'b1};
            end else begin
                rem_next  = shifted;
                root_next = {root_reg[DIST_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        root_reg <= root_next;
        src_reg  <= src_next;
    end

    assign done = busy_reg && (cnt_reg == 5'(STEPS - 1));
    assign root = root_next;

endmodule

// ===== sv/periodic_nearest_atom_search.sv =====
// Periodic nearest-atom search. Load words (command 0) write one atom into the
// position RAM; the acknowledge passes through the ST_OUT state and appears in
// the output register once that register is free. A query word (command 1)
// first forms its 27 lattice images, one per cycle, then streams the position
// RAM once over atom_count entries (capped at MAX_ATOMS) through the RAM read,
// the squares register and the running compare, with all 27 images compared
// against each atom in parallel. A bit-serial square root then forms the root
// and the answer is loaded into the output register; one word is processed at
// a time. A result waiting at the output does not block the next word from
// being accepted, but that word then holds in its last stage until the output
// is free.
module periodic_nearest_atom_search import pnas_pkg::*; #(
    parameter int MAX_ATOMS  = MAX_ATOMS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [CFG_BITS-1:0]            cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic [IDX_BITS-1:0]            s_atom_index,
    input  logic signed [COORD_BITS-1:0]   s_pos_x,
    input  logic signed [COORD_BITS-1:0]   s_pos_y,
    input  logic signed [COORD_BITS-1:0]   s_pos_z,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_is_query,
    output logic                           m_found,
    output logic [IDX_BITS-1:0]            m_nearest_index,
    output logic [DSQ_BITS-1:0]            m_distance_squared,
    output logic [DIST_BITS-1:0]           m_distance
);

    localparam int AW   = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CW   = $clog2(MAX_ATOMS + 1);
    localparam int IW   = COORD_BITS + 2;
    localparam int DW   = COORD_BITS + 3;
    localparam int SQW  = 2 * DW;
    localparam int SMW  = SQW + 2;
    localparam int PW   = 3 * COORD_BITS;
    localparam int TREE = 32;

    logic [CFG_BITS-1:0] lat_a_reg, lat_b_reg, lat_c_reg;
    logic [CNT_BITS-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_a_reg <= '0;
            lat_b_reg <= '0;
            lat_c_reg <= '0;
            count_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LATTICE_A:  lat_a_reg <= cfg_data;
                REG_LATTICE_B:  lat_b_reg <= cfg_data;
                REG_LATTICE_C:  lat_c_reg <= cfg_data;
                REG_ATOM_COUNT: count_reg <= cfg_data[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic signed [COORD_BITS-1:0] comp(logic [CFG_BITS-1:0] p, int k);
        return p[k*COORD_BITS +: COORD_BITS];
    endfunction

    // shift select: 0 is -1, 1 is 0, 2 is +1
    function automatic logic [IW-1:0] shift_term(logic [1:0] sel,
                                                 logic signed [COORD_BITS-1:0] v);
        case (sel)
            2'd0:    return -IW'(v);
            2'd2:    return IW'(v);
            default: return '0;
        endcase
    endfunction

    state_t state_reg, state_next;
    logic                         cmd_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg;
    logic [4:0]                   img_reg, img_next;
    logic [1:0]                   si_reg, sj_reg, sk_reg;
    logic signed [IW-1:0]         imgx_reg [IMAGES];
    logic signed [IW-1:0]         imgy_reg [IMAGES];
    logic signed [IW-1:0]         imgz_reg [IMAGES];
    logic [CW-1:0]                active_cnt;
    logic [CW-1:0]                rd_cnt_reg;
    logic                         rd_vld_reg, sq_vld_reg;
    logic [AW-1:0]                rd_idx_reg, sq_idx_reg;
    logic [SQW-1:0]               sqx_reg [IMAGES];
    logic [SQW-1:0]               sqy_reg [IMAGES];
    logic [SQW-1:0]               sqz_reg [IMAGES];
    logic                         have_reg;
    logic [SMW-1:0]               best_reg;
    logic [AW-1:0]                best_idx_reg;
    logic [4:0]                   best_img_reg;
    logic [PW-1:0]                ram_rd;
    logic                         ram_we;
    logic [DSQ_BITS-1:0]          dsq_sat;
    logic                         sqrt_start, sqrt_done;
    logic [DIST_BITS-1:0]         sqrt_root;
    logic                         accept, out_free;
    logic                         out_vld_reg;
    logic                         o_query_reg, o_found_reg;
    logic [IDX_BITS-1:0]          o_idx_reg;
    logic [DSQ_BITS-1:0]          o_dsq_reg;
    logic [DIST_BITS-1:0]         o_dist_reg;
    logic                         load_fin;

    assign active_cnt = (CW'(count_reg) > CW'(MAX_ATOMS)) ? CW'(MAX_ATOMS) : CW'(count_reg);
    assign out_free   = !out_vld_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign ram_we     = accept && (s_command == CMD_LOAD) && (32'(s_atom_index) < MAX_ATOMS);

    pnas_ram #(.WIDTH(PW), .DEPTH(1 << AW)) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (AW'(s_atom_index)),
        .wr_data ({s_pos_z, s_pos_y, s_pos_x}),
        .rd_addr (rd_cnt_reg[AW-1:0]),
        .rd_data (ram_rd)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = (s_command == CMD_QUERY) ? ST_IMAGE : ST_OUT;
            ST_IMAGE: if (img_reg == 5'(IMAGES - 1)) state_next = ST_SCAN;
            ST_SCAN:  if (rd_cnt_reg >= active_cnt && !rd_vld_reg && !sq_vld_reg)
                          state_next = ST_SQRT;
            ST_SQRT:  if (sqrt_done) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        img_next   = (state_reg == ST_IMAGE) ? img_reg + 5'd1 : '0;
        sqrt_start = (state_reg == ST_SCAN) && (state_next == ST_SQRT);
        load_fin   = (state_reg == ST_OUT) && out_free;
        dsq_sat    = (best_reg > SMW'({DSQ_BITS{1'b1}})) ? {DSQ_BITS{1'b1}}
                                                         : DSQ_BITS'(best_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            img_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            sq_vld_reg  <= 1'b0;
            rd_cnt_reg  <= '0;
            out_vld_reg <= 1'b0;
            have_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            img_reg    <= img_next;
            rd_vld_reg <= (state_reg == ST_SCAN) && (rd_cnt_reg < active_cnt);
            sq_vld_reg <= rd_vld_reg;
            if (state_reg == ST_SCAN && rd_cnt_reg < active_cnt)
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
            else if (state_reg != ST_SCAN)
                rd_cnt_reg <= '0;
            if (accept)
                have_reg <= 1'b0;
            else if (sq_vld_reg)
                have_reg <= 1'b1;
            if (load_fin)
                out_vld_reg <= 1'b1;
            else if (out_vld_reg && m_ready)
                out_vld_reg <= 1'b0;
        end
    end

    // best over the 27 images of one atom, lower image kept on a tie
    logic [SMW-1:0] row_best;
    logic [4:0]     row_img;
    logic [SMW-1:0] tree_val [TREE];
    logic [4:0]     tree_img [TREE];
    always_comb begin
        for (int m = 0; m < IMAGES; m++) begin
            tree_val[m] = SMW'(sqx_reg[m]) + SMW'(sqy_reg[m]) + SMW'(sqz_reg[m]);
            tree_img[m] = 5'(m);
        end
        for (int m = IMAGES; m < TREE; m++) begin
            tree_val[m] = '1;
            tree_img[m] = 5'(m);
        end
        for (int lvl = 0; lvl < 5; lvl++) begin
            for (int m = 0; m < TREE / 2; m++) begin
                if (m < (TREE >> (lvl + 1))) begin
                    if (tree_val[2*m+1] < tree_val[2*m]) begin
                        tree_val[m] = tree_val[2*m+1];
                        tree_img[m] = tree_img[2*m+1];
                    end else begin
                        tree_val[m] = tree_val[2*m];
                        tree_img[m] = tree_img[2*m];
                    end
                end
            end
        end
        row_best = tree_val[0];
        row_img  = tree_img[0];
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_command;
            px_reg  <= s_pos_x;
            py_reg  <= s_pos_y;
            pz_reg  <= s_pos_z;
            si_reg  <= 2'd0;
            sj_reg  <= 2'd0;
            sk_reg  <= 2'd0;
        end
        if (state_reg == ST_IMAGE) begin
            imgx_reg[img_reg] <= IW'(px_reg)
                + shift_term(si_reg, comp(lat_a_reg, 0))
                + shift_term(sj_reg, comp(lat_b_reg, 0))
                + shift_term(sk_reg, comp(lat_c_reg, 0));
            imgy_reg[img_reg] <= IW'(py_reg)
                + shift_term(si_reg, comp(lat_a_reg, 1))
                + shift_term(sj_reg, comp(lat_b_reg, 1))
                + shift_term(sk_reg, comp(lat_c_reg, 1));
            imgz_reg[img_reg] <= IW'(pz_reg)
                + shift_term(si_reg, comp(lat_a_reg, 2))
                + shift_term(sj_reg, comp(lat_b_reg, 2))
                + shift_term(sk_reg, comp(lat_c_reg, 2));
            if (sk_reg == 2'd2) begin
                sk_reg <= 2'd0;
                if (sj_reg == 2'd2) begin
                    sj_reg <= 2'd0;
                    si_reg <= si_reg + 2'd1;
                end else begin
                    sj_reg <= sj_reg + 2'd1;
                end
            end else begin
                sk_reg <= sk_reg + 2'd1;
            end
        end
        if (rd_vld_reg) begin
            for (int m = 0; m < IMAGES; m++) begin
                logic signed [DW-1:0] dx, dy, dz;
                dx = DW'(imgx_reg[m]) - DW'(comp(ram_rd, 0));
                dy = DW'(imgy_reg[m]) - DW'(comp(ram_rd, 1));
                dz = DW'(imgz_reg[m]) - DW'(comp(ram_rd, 2));
                sqx_reg[m] <= SQW'(dx * dx);
                sqy_reg[m] <= SQW'(dy * dy);
                sqz_reg[m] <= SQW'(dz * dz);
            end
            sq_idx_reg <= rd_idx_reg;
        end
        rd_idx_reg <= rd_cnt_reg[AW-1:0];
        if (sq_vld_reg) begin
            // image order dominates atom order on ties
            if (!have_reg || row_best < best_reg ||
                (row_best == best_reg && row_img < best_img_reg)) begin
                best_reg     <= row_best;
                best_idx_reg <= sq_idx_reg;
                best_img_reg <= row_img;
            end
        end
        if (load_fin) begin
            o_query_reg <= cmd_reg;
            o_found_reg <= cmd_reg && have_reg;
            o_idx_reg   <= (cmd_reg && have_reg) ? IDX_BITS'(best_idx_reg) : '0;
            o_dsq_reg   <= (cmd_reg && have_reg) ? dsq_sat : '0;
            o_dist_reg  <= (cmd_reg && have_reg) ? sqrt_root : '0;
        end
    end

    logic [DIST_BITS-1:0] root_hold_reg;
    logic [DIST_BITS-1:0] root_w;
    always_ff @(posedge aclk) begin
        if (sqrt_done) root_hold_reg <= root_w;
    end
    assign sqrt_root = root_hold_reg;

    pnas_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .value   (dsq_sat),
        .done    (sqrt_done),
        .root    (root_w)
    );

    assign m_valid            = out_vld_reg;
    assign m_is_query         = o_query_reg;
    assign m_found            = o_found_reg;
    assign m_nearest_index    = o_idx_reg;
    assign m_distance_squared = o_dsq_reg;
    assign m_distance         = o_dist_reg;

endmodule

// ===== sv/pnas_checker.sv =====
module pnas_checker import pnas_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_is_query,
    input logic                 m_found,
    input logic [IDX_BITS-1:0]  m_nearest_index,
    input logic [DSQ_BITS-1:0]  m_distance_squared,
    input logic [DIST_BITS-1:0] m_distance
);

    a_ack_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_query |-> !m_found && m_distance_squared == '0)
        else $error("load acknowledge carries data");

    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_nearest_index == '0 && m_distance == '0)
        else $error("not-found answer carries data");

    a_root_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> DSQ_BITS'(m_distance) * DSQ_BITS'(m_distance) <= m_distance_squared)
        else $error("distance exceeds root");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance_squared))
        else $error("result dropped while stalled");

    a_busy_after_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready straight after a word");

endmodule

bind periodic_nearest_atom_search pnas_checker u_pnas_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_is_query         (m_is_query),
    .m_found            (m_found),
    .m_nearest_index    (m_nearest_index),
    .m_distance_squared (m_distance_squared),
    .m_distance         (m_distance)
);

// ===== verif/pnas_checker.sv =====
module pnas_scoreboard import pnas_pkg::*; (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [CFG_BITS-1:0]             cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_command,
    input  logic [IDX_BITS-1:0]             s_atom_index,
    input  logic signed [COORD_BITS_DEF-1:0] s_pos_x,
    input  logic signed [COORD_BITS_DEF-1:0] s_pos_y,
    input  logic signed [COORD_BITS_DEF-1:0] s_pos_z,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_is_query,
    input  logic                            m_found,
    input  logic [IDX_BITS-1:0]             m_nearest_index,
    input  logic [DSQ_BITS-1:0]             m_distance_squared,
    input  logic [DIST_BITS-1:0]            m_distance,
    output int                              errors,
    output int                              outstanding,
    output int                              n_loads,
    output int                              n_queries,
    output int                              n_found
);

    localparam int CB = COORD_BITS_DEF;

    typedef struct packed {
        logic                 is_query;
        logic                 found;
        logic [IDX_BITS-1:0]  nearest;
        logic [DSQ_BITS-1:0]  dsq;
        logic [DIST_BITS-1:0] root;
    } answer_t;

    logic [CFG_BITS-1:0] lattice [3];
    logic [CNT_BITS-1:0] active_count;
    logic [3*CB-1:0]     atom_mem [MAX_ATOMS_DEF];
    answer_t             answers_due [$];

    function automatic longint field_of(input logic [3*CB-1:0] v, input int k);
        logic signed [CB-1:0] c;
        c = v[k*CB +: CB];
        return longint'(c);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic answer_t search_nearest(input longint px, input longint py,
                                               input longint pz);
        answer_t a;
        longint img [3];
        longint p [3];
        longint d;
        longint unsigned s, best;
        int n_act, best_n;
        bit have;
        p[0] = px; p[1] = py; p[2] = pz;
        n_act = (active_count > MAX_ATOMS_DEF) ? MAX_ATOMS_DEF : int'(active_count);
        have = 0; best = 0; best_n = 0;
        for (int i = -1; i <= 1; i++)
            for (int j = -1; j <= 1; j++)
                for (int l = -1; l <= 1; l++) begin
                    for (int k = 0; k < 3; k++)
                        img[k] = p[k] + i * field_of(lattice[0], k)
                               + j * field_of(lattice[1], k)
                               + l * field_of(lattice[2], k);
                    for (int n = 0; n < n_act; n++) begin
                        s = 0;
                        for (int k = 0; k < 3; k++) begin
                            d = img[k] - field_of(atom_mem[n], k);
                            s += longint'(d * d);
                        end
                        if (!have || s < best) begin
                            have = 1;
                            best = s;
                            best_n = n;
                        end
                    end
                end
        a = '0;
        a.is_query = CMD_QUERY;
        if (have) begin
            if (best > (64'd1 << DSQ_BITS) - 1) best = (64'd1 << DSQ_BITS) - 1;
            a.found   = 1'b1;
            a.nearest = best_n[IDX_BITS-1:0];
            a.dsq     = best[DSQ_BITS-1:0];
            a.root    = DIST_BITS'(floor_sqrt(best));
        end
        return a;
    endfunction

    initial begin
        errors = 0; outstanding = 0; n_loads = 0; n_queries = 0; n_found = 0;
    end

    always @(posedge aclk) begin
        answer_t want, got;
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) lattice[k] = '0;
            active_count = '0;
            answers_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_LATTICE_A:  lattice[0] = cfg_data;
                    REG_LATTICE_B:  lattice[1] = cfg_data;
                    REG_LATTICE_C:  lattice[2] = cfg_data;
                    REG_ATOM_COUNT: active_count = cfg_data[CNT_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_command == CMD_LOAD) begin
                    atom_mem[s_atom_index] = {s_pos_z, s_pos_y, s_pos_x};
                    want = '0;
                    want.is_query = CMD_LOAD;
                    n_loads++;
                end else begin
                    want = search_nearest(longint'(s_pos_x), longint'(s_pos_y),
                                          longint'(s_pos_z));
                    n_queries++;
                    if (want.found) n_found++;
                end
                answers_due = {answers_due, want};
            end
            if (m_valid && m_ready) begin
                got = {m_is_query, m_found, m_nearest_index, m_distance_squared, m_distance};
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, got);
                    errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (got.is_query !== want.is_query) begin
                        $display("%0t: is_query exp %h got %h", $time, want.is_query,
                                 got.is_query);
                        errors++;
                    end
                    if (got.found !== want.found) begin
                        $display("%0t: found exp %h got %h", $time, want.found, got.found);
                        errors++;
                    end
                    if (got.nearest !== want.nearest) begin
                        $display("%0t: nearest_index exp %0d got %0d", $time, want.nearest,
                                 got.nearest);
                        errors++;
                    end
                    if (got.dsq !== want.dsq) begin
                        $display("%0t: distance_squared exp %0d got %0d", $time, want.dsq,
                                 got.dsq);
                        errors++;
                    end
                    if (got.root !== want.root) begin
                        $display("%0t: distance exp %0d got %0d", $time, want.root,
                                 got.root);
                        errors++;
                    end
                end
            end
            outstanding = answers_due.size();
        end
    end

endmodule

// ===== verif/tb_periodic_nearest_atom_search.sv =====
module tb_periodic_nearest_atom_search;
    import pnas_pkg::*;

    localparam int CB        = COORD_BITS_DEF;
    localparam int LIMIT     = 3000000;
    localparam int HOLD_LEN  = 600;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]     cfg_index = '0;
    logic [CFG_BITS-1:0]         cfg_data = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_command = CMD_LOAD;
    logic [IDX_BITS-1:0]         s_atom_index = '0;
    logic signed [CB-1:0]        s_pos_x = '0;
    logic signed [CB-1:0]        s_pos_y = '0;
    logic signed [CB-1:0]        s_pos_z = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic                        m_is_query;
    logic                        m_found;
    logic [IDX_BITS-1:0]         m_nearest_index;
    logic [DSQ_BITS-1:0]         m_distance_squared;
    logic [DIST_BITS-1:0]        m_distance;

    int  errors, outstanding, n_loads, n_queries, n_found;
    int  cycles = 0;
    bit  burst = 0;
    bit  hold_req = 0;
    bit  hold_done = 0;
    bit  written [MAX_ATOMS_DEF];
    int  prefix = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    periodic_nearest_atom_search u_dut (.*);

    pnas_scoreboard u_chk (.*);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1;
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
            end else if (burst) begin
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 99) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    function automatic logic [CB-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(CB-1){1'b0}}};
            1: return {1'b0, {(CB-1){1'b1}}};
            2: return CB'($urandom);
            3, 4: return CB'(($urandom_range(0, 8) - 4) * 1024);
            default: return CB'($urandom_range(0, 131072) - 65536);
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] rand_lattice();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return {3{1'b0, {(CB-1){1'b1}}}};
            3: return {3{1'b1, {(CB-1){1'b0}}}};
            default: return {rand_coord(), rand_coord(), rand_coord()};
        endcase
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    task automatic send_word(input logic cmd, input logic [IDX_BITS-1:0] idx,
                             input logic [CB-1:0] x, input logic [CB-1:0] y,
                             input logic [CB-1:0] z);
        int gap;
        int r;
        r = $urandom_range(0, 19);
        gap = (r < 13) ? 0 : (r < 19) ? $urandom_range(1, 3) : $urandom_range(10, 50);
        if (!burst && gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_atom_index <= idx;
        s_pos_x      <= x;
        s_pos_y      <= y;
        s_pos_z      <= z;
        do @(posedge aclk); while (!s_ready);
        if (cmd == CMD_LOAD) begin
            written[idx] = 1;
            while (prefix < MAX_ATOMS_DEF && written[prefix]) prefix++;
        end
    endtask

    task automatic end_phase();
        s_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic load_atom(input logic [IDX_BITS-1:0] idx);
        send_word(CMD_LOAD, idx, rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic ask(input logic [CB-1:0] x, input logic [CB-1:0] y,
                       input logic [CB-1:0] z);
        send_word(CMD_QUERY, IDX_BITS'($urandom), x, y, z);
    endtask

    initial begin
        logic [CB-1:0] cmax, cmin;
        int cnt, q_pct, n_items, ix;
        cmax = {1'b0, {(CB-1){1'b1}}};
        cmin = {1'b1, {(CB-1){1'b0}}};
        foreach (written[k]) written[k] = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty store, extremes, duplicate atoms for ties
        ask(cmax, cmin, '0);
        send_word(CMD_LOAD, 8'd0, cmax, cmax, cmax);
        send_word(CMD_LOAD, 8'd1, cmin, cmin, cmin);
        send_word(CMD_LOAD, 8'd2, '0, '0, '0);
        send_word(CMD_LOAD, 8'd3, '0, '0, '0);
        send_word(CMD_LOAD, 8'd255, 20'h55555, 20'haaaaa, 20'h0f0f0);
        ask('0, '0, '0);
        for (int k = 4; k < 16; k++) load_atom(k[7:0]);
        end_phase();

        cfg_write(REG_LATTICE_A, {3{cmax}});
        cfg_write(REG_LATTICE_B, {3{cmin}});
        cfg_write(REG_LATTICE_C, '0);
        cfg_write(REG_ATOM_COUNT, CFG_BITS'(16));
        ask(cmax, cmax, cmax);
        ask(cmin, cmin, cmin);
        ask('0, '0, '0);
        ask(cmax, cmin, cmax);
        end_phase();
        cfg_write(REG_LATTICE_A, '0);
        cfg_write(REG_LATTICE_B, '0);
        cfg_write(REG_ATOM_COUNT, CFG_BITS'(1));
        ask(cmin, cmax, '0);
        ask('0, '0, '0);
        end_phase();

        for (int ph = 0; ph < 11; ph++) begin
            burst = (ph % 4 == 1);
            if (ph == 3) begin
                for (int k = 0; k < MAX_ATOMS_DEF; k++)
                    if (!written[k]) load_atom(k[7:0]);
                end_phase();
            end
            cfg_write(REG_LATTICE_A, rand_lattice());
            cfg_write(REG_LATTICE_B, rand_lattice());
            cfg_write(REG_LATTICE_C, rand_lattice());
            if (ph == 3) cnt = 256;
            else if (ph == 7 && prefix == MAX_ATOMS_DEF) cnt = 511;
            else if (ph == 5) cnt = 0;
            else cnt = $urandom_range(1, prefix);
            cfg_write(REG_ATOM_COUNT, CFG_BITS'(cnt));
            q_pct = (cnt > 64) ? 30 : 55;
            n_items = 100;
            if (ph == 2) hold_req = 1;
            for (int n = 0; n < n_items; n++) begin
                if ($urandom_range(0, 99) < q_pct) begin
                    ask(rand_coord(), rand_coord(), rand_coord());
                end else begin
                    if ($urandom_range(0, 9) < 7 && prefix < MAX_ATOMS_DEF)
                        ix = $urandom_range(0, prefix);
                    else
                        ix = $urandom_range(0, MAX_ATOMS_DEF - 1);
                    load_atom(ix[7:0]);
                end
            end
            end_phase();
        end

        burst = 0;
        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Covered %0d loads and %0d queries (%0d with a nearest atom found),",
                 n_loads, n_queries, n_found);
        $display("over several lattice and atom count settings, saturated count included.");
        if (errors == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pnas_pkg.sv
sv/pnas_ram.sv
sv/pnas_sqrt.sv
sv/periodic_nearest_atom_search.sv
sv/pnas_checker.sv
verif/pnas_checker.sv
verif/tb_periodic_nearest_atom_search.sv
